[rtl/core/rsp_pkg.sv]
// Shared types and constants for the RESP stream parser.
// No dependencies; imported by rsp_core, rsp_fifo and resp_stream_parser.
`default_nettype none
package rsp_pkg;

  // Parser modes, one-hot
  typedef enum logic [8:0] {
    M_IDLE   = 9'b000000001,
    M_LINE   = 9'b000000010,
    M_HSTART = 9'b000000100,
    M_HSIGN  = 9'b000001000,
    M_HDIG   = 9'b000010000,
    M_HLF    = 9'b000100000,
    M_BDATA  = 9'b001000000,
    M_BCR    = 9'b010000000,
    M_BLF    = 9'b100000000
  } mode_e;

  // Header kinds (line kinds double as token types)
  localparam logic [2:0] KIND_SIMPLE = 3'd0;
  localparam logic [2:0] KIND_ERROR  = 3'd1;
  localparam logic [2:0] KIND_INT    = 3'd2;
  localparam logic [2:0] KIND_BULK   = 3'd3;
  localparam logic [2:0] KIND_ARRAY  = 3'd4;

  localparam logic [1:0] TT_SIMPLE = 2'd0;
  localparam logic [1:0] TT_BULK   = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_PREFIX = 3'd1;
  localparam logic [2:0] ERR_HEADER = 3'd2;
  localparam logic [2:0] ERR_DEPTH  = 3'd3;
  localparam logic [2:0] ERR_LIMIT  = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_MAX_BULK  = 2'd0;
  localparam logic [1:0] REG_MAX_ARRAY = 2'd1;

  localparam int unsigned BULK_LIM_W = 24;
  localparam int unsigned ARR_LIM_W  = 16;
  localparam int unsigned MSG_LEN_W  = 24;
  localparam logic [BULK_LIM_W-1:0] MAX_BULK_RST  = 24'd1048576;
  localparam logic [ARR_LIM_W-1:0]  MAX_ARRAY_RST = 16'd1024;

  // Protocol characters
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Result queue
  localparam int unsigned FIFO_DEPTH = 4;

  typedef struct packed {
    logic                 payload_valid;
    logic [7:0]           payload_byte;
    logic [1:0]           token_type;
    logic                 token_end;
    logic                 token_null;
    logic                 message_end;
    logic [MSG_LEN_W-1:0] message_length;
    logic [2:0]           error_code;
    logic                 last_result;
  } result_t;

endpackage
`default_nettype wire

[rtl/core/rsp_fifo.sv]
// Four-entry result queue taking up to two results per transaction.
// Depends on rsp_pkg.
`default_nettype none
module rsp_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [1:0]      push_cnt_i,
  input  rsp_pkg::result_t     push0_i,
  input  rsp_pkg::result_t     push1_i,
  output logic                 space_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output rsp_pkg::result_t     out_o
);
  import rsp_pkg::*;

  localparam int unsigned PW = $clog2(FIFO_DEPTH);

  result_t         mem_q [FIFO_DEPTH];
  logic [PW-1:0]   wp_q, rp_q;
  logic [PW:0]     cnt_q;
  logic            pop;

  assign pop         = out_valid_o & out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_o       = mem_q[rp_q];
  // room for the worst case of two results
  assign space_o     = (cnt_q <= (PW+1)'(FIFO_DEPTH - 2));

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + PW'(push_cnt_i);
      if (pop) rp_q <= rp_q + PW'(1);
      cnt_q <= cnt_q + (PW+1)'(push_cnt_i) - (PW+1)'(pop);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wp_q] <= push0_i;
    if (push_cnt_i == 2'd2) mem_q[wp_q + PW'(1)] <= push1_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW+1)'(FIFO_DEPTH)) else $error("result queue overflow");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt_i != 2'd0) |-> (cnt_q <= (PW+1)'(FIFO_DEPTH - 2) || pop))
    else $error("push without room");
  a_pop_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (rp_q == $past(rp_q) + PW'(1))) else $error("read pointer slip");

endmodule
`default_nettype wire

[rtl/core/rsp_core.sv]
// RESP parse engine: mode register, header accumulator, array count stack.
// Depends on rsp_pkg. Produces up to two results per accepted byte.
`default_nettype none
module rsp_core #(
  parameter int unsigned NEST_DEPTH  = 8,
  parameter int unsigned LENGTH_BITS = 24
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           accept_i,
  input  wire logic [7:0]                     byte_i,
  input  wire logic [rsp_pkg::BULK_LIM_W-1:0] max_bulk_i,
  input  wire logic [rsp_pkg::ARR_LIM_W-1:0]  max_array_i,
  output logic [1:0]                          res_cnt_o,
  output rsp_pkg::result_t                    res0_o,
  output rsp_pkg::result_t                    res1_o
);
  import rsp_pkg::*;

  localparam int unsigned HW = LENGTH_BITS + 1;
  localparam int unsigned CW = (HW > BULK_LIM_W) ? HW : BULK_LIM_W;
  localparam int unsigned LW = $clog2(NEST_DEPTH + 1);
  localparam int unsigned IW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam logic [MSG_LEN_W-1:0] LEN_SAT = (LENGTH_BITS >= MSG_LEN_W) ?
    {MSG_LEN_W{1'b1}} : MSG_LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);
  localparam logic [HW+3:0] HDR_CAP = (HW+4)'(1) << LENGTH_BITS;

  mode_e                  mode_q, mode_d;
  logic [2:0]             kind_q, kind_d;
  logic [HW-1:0]          hval_q, hval_d;
  logic                   hneg_q, hneg_d;
  logic [LENGTH_BITS-1:0] brem_q, brem_d;
  logic                   crp_q, crp_d;
  logic [LW-1:0]          level_q, level_d;
  logic [MSG_LEN_W-1:0]   mb_q, mb_d, mb_inc;
  logic [ARR_LIM_W-1:0]   counts_q [NEST_DEPTH];

  logic                   push;
  logic [ARR_LIM_W-1:0]   push_val;
  logic                   pop_found;
  logic [IW-1:0]          pop_idx;
  logic [HW+3:0]          hv_next;
  logic                   is_digit, neg_hdr;
  logic [CW-1:0]          hval_ext;
  logic                   fin, fin_te, fin_tn, err, pop_dec;
  logic [1:0]             fin_tt;
  logic [2:0]             ecode;
  result_t                r0, r1, rr;
  logic [1:0]             n;

  // highest open level whose count still exceeds one
  always_comb begin
    pop_found = 1'b0;
    pop_idx   = '0;
    for (int i = 0; i < NEST_DEPTH; i++) begin
      if ((LW'(i) < level_q) && (counts_q[i] > ARR_LIM_W'(1))) begin
        pop_found = 1'b1;
        pop_idx   = IW'(i);
      end
    end
  end

  // header digit step, saturating at the cap
  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  always_comb begin
    hv_next = {hval_q, 3'b000} + {2'b00, hval_q, 1'b0}
            + (HW+4)'(byte_i - CH_ZERO);
    if (hv_next > HDR_CAP) hv_next = HDR_CAP;
  end
  assign hval_ext = CW'(hval_q);
  assign neg_hdr  = hneg_q && (hval_q != '0);

  // message byte count
  always_comb begin
    if (mode_q == M_IDLE && level_q == '0) mb_inc = MSG_LEN_W'(1);
    else if (mb_q < LEN_SAT)                mb_inc = mb_q + MSG_LEN_W'(1);
    else                                    mb_inc = mb_q;
  end

  // next state and results
  always_comb begin
    mode_d = mode_q; kind_d = kind_q; hval_d = hval_q; hneg_d = hneg_q;
    brem_d = brem_q; crp_d = crp_q; level_d = level_q; mb_d = mb_inc;
    push = 1'b0; push_val = '0; pop_dec = 1'b0;
    fin = 1'b0; fin_te = 1'b0; fin_tt = TT_SIMPLE; fin_tn = 1'b0;
    err = 1'b0; ecode = ERR_NONE;
    r0 = '0; r1 = '0; rr = '0; n = 2'd0;

    unique case (mode_q)
      M_IDLE: begin
        hval_d = '0; hneg_d = 1'b0; crp_d = 1'b0;
        case (byte_i)
          CH_PLUS:   begin kind_d = KIND_SIMPLE; mode_d = M_LINE;   end
          CH_MINUS:  begin kind_d = KIND_ERROR;  mode_d = M_LINE;   end
          CH_COLON:  begin kind_d = KIND_INT;    mode_d = M_LINE;   end
          CH_DOLLAR: begin kind_d = KIND_BULK;   mode_d = M_HSTART; end
          CH_STAR:   begin kind_d = KIND_ARRAY;  mode_d = M_HSTART; end
          default:   begin err = 1'b1; ecode = ERR_PREFIX; end
        endcase
      end
      M_LINE: begin
        if (crp_q && byte_i == CH_LF) begin
          crp_d = 1'b0;
          fin = 1'b1; fin_te = 1'b1; fin_tt = kind_q[1:0];
        end else begin
          if (crp_q) begin
            r0.payload_valid = 1'b1; r0.payload_byte = CH_CR;
            r0.token_type = kind_q[1:0];
            n = 2'd1;
          end
          crp_d = (byte_i == CH_CR);
          if (byte_i != CH_CR) begin
            rr.payload_valid = 1'b1; rr.payload_byte = byte_i;
            rr.token_type = kind_q[1:0];
            if (n == 2'd0) r0 = rr; else r1 = rr;
            n = n + 2'd1;
          end
        end
      end
      M_HSTART, M_HSIGN, M_HDIG: begin
        if (is_digit) begin
          hval_d = hv_next[HW-1:0];
          mode_d = M_HDIG;
        end else if (byte_i == CH_MINUS && mode_q == M_HSTART) begin
          hneg_d = 1'b1;
          mode_d = M_HSIGN;
        end else if (byte_i == CH_CR && mode_q == M_HDIG) begin
          mode_d = M_HLF;
        end else begin
          err = 1'b1; ecode = ERR_HEADER;
        end
      end
      M_HLF: begin
        if (byte_i != CH_LF) begin
          err = 1'b1; ecode = ERR_HEADER;
        end else if (kind_q == KIND_BULK) begin
          if (neg_hdr) begin
            fin = 1'b1; fin_te = 1'b1; fin_tt = TT_BULK; fin_tn = 1'b1;
          end else if (hval_q[LENGTH_BITS] || hval_ext > CW'(max_bulk_i)) begin
            err = 1'b1; ecode = ERR_LIMIT;
          end else begin
            brem_d = hval_q[LENGTH_BITS-1:0];
            mode_d = (hval_q == '0) ? M_BCR : M_BDATA;
          end
        end else begin
          if (neg_hdr || hval_q == '0) begin
            fin = 1'b1;
          end else if (hval_q[LENGTH_BITS] || hval_ext > CW'(max_array_i)) begin
            err = 1'b1; ecode = ERR_LIMIT;
          end else if (level_q >= LW'(NEST_DEPTH)) begin
            err = 1'b1; ecode = ERR_DEPTH;
          end else begin
            push     = 1'b1;
            push_val = hval_q[ARR_LIM_W-1:0];
            level_d  = level_q + LW'(1);
            mode_d   = M_IDLE;
          end
        end
      end
      M_BDATA: begin
        r0.payload_valid = 1'b1; r0.payload_byte = byte_i; r0.token_type = TT_BULK;
        n = 2'd1;
        if (brem_q != '0) brem_d = brem_q - LENGTH_BITS'(1);
        if (brem_d == '0) mode_d = M_BCR;
      end
      M_BCR: begin
        if (byte_i == CH_CR) mode_d = M_BLF;
        else begin err = 1'b1; ecode = ERR_HEADER; end
      end
      M_BLF: begin
        if (byte_i == CH_LF) begin
          fin = 1'b1; fin_te = 1'b1; fin_tt = TT_BULK;
        end else begin
          err = 1'b1; ecode = ERR_HEADER;
        end
      end
      default: begin
        mode_d = M_IDLE;
      end
    endcase

    // element complete: pop full levels, maybe close the message
    if (fin) begin
      mode_d = M_IDLE;
      crp_d  = 1'b0;
      if (pop_found) begin
        pop_dec = 1'b1;
        level_d = LW'(pop_idx) + LW'(1);
      end else begin
        level_d = '0;
      end
      if (!pop_found || fin_te) begin
        r0.token_type = fin_te ? fin_tt : TT_SIMPLE;
        r0.token_end  = fin_te;
        r0.token_null = fin_tn;
        if (!pop_found) begin
          r0.message_end    = 1'b1;
          r0.message_length = mb_inc;
          mb_d = '0;
        end
        n = 2'd1;
      end
    end

    // error: report once and drop all parse state
    if (err) begin
      r0 = '0;
      r0.error_code = ecode;
      n = 2'd1;
      mode_d = M_IDLE; kind_d = KIND_SIMPLE; hval_d = '0; hneg_d = 1'b0;
      brem_d = '0; crp_d = 1'b0; level_d = '0; mb_d = '0;
    end

    if (n == 2'd1) r0.last_result = 1'b1;
    if (n == 2'd2) r1.last_result = 1'b1;
  end

  assign res_cnt_o = accept_i ? n : 2'd0;
  assign res0_o    = r0;
  assign res1_o    = r1;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      kind_q  <= KIND_SIMPLE;
      hval_q  <= '0;
      hneg_q  <= 1'b0;
      brem_q  <= '0;
      crp_q   <= 1'b0;
      level_q <= '0;
      mb_q    <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      kind_q  <= kind_d;
      hval_q  <= hval_d;
      hneg_q  <= hneg_d;
      brem_q  <= brem_d;
      crp_q   <= crp_d;
      level_q <= level_d;
      mb_q    <= mb_d;
    end
  end

  // array count stack
  always_ff @(posedge clk_i) begin
    if (accept_i && push)    counts_q[level_q[IW-1:0]] <= push_val;
    if (accept_i && pop_dec) counts_q[pop_idx] <= counts_q[pop_idx] - ARR_LIM_W'(1);
  end

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LW'(NEST_DEPTH)) else $error("nesting level out of range");
  a_msg_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_cnt_o != 2'd0 && res0_o.message_end) |-> (res0_o.error_code == ERR_NONE
      && level_d == '0)) else $error("message end with error or open levels");
  a_err_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && err) |=> (mode_q == M_IDLE && level_q == '0 && mb_q == '0))
    else $error("error did not return to idle");

endmodule
`default_nettype wire

[rtl/core/resp_stream_parser.sv]
// RESP stream parser top level: config registers, parse engine, result queue.
// Depends on rsp_pkg, rsp_core and rsp_fifo.
// Each result is written into the result queue when its byte is taken, and leaves in order.
// Throughput: one byte per cycle while the queue has room for two results; a byte
// giving two results (bare CR in a line) writes both into the four-entry result queue.
// Reset: asynchronous, active low; parser idle, limits at 1048576 and 1024.
`default_nettype none
module resp_stream_parser #(
  parameter int unsigned NEST_DEPTH  = 8,
  parameter int unsigned LENGTH_BITS = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [0] payload_valid, [8:1] payload_byte,
                                           // [9] token_end, [10] token_null,
                                           // [11] message_end, [35:12] message_length,
                                           // [38:36] error_code, [39] zero
  output logic [1:0]       m_axis_tuser,   // [1:0] token_type
  output logic             m_axis_tlast,   // last_result
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);
  import rsp_pkg::*;

  logic [BULK_LIM_W-1:0] max_bulk_q;
  logic [ARR_LIM_W-1:0]  max_array_q;
  logic                  accept, space;
  logic [1:0]            res_cnt;
  result_t               res0, res1, head;

  assign cfg_ready_o   = 1'b1;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = space;

  // limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bulk_q  <= MAX_BULK_RST;
      max_array_q <= MAX_ARRAY_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MAX_BULK:  max_bulk_q  <= cfg_data_i[BULK_LIM_W-1:0];
        REG_MAX_ARRAY: max_array_q <= cfg_data_i[ARR_LIM_W-1:0];
        default: ;
      endcase
    end
  end

  rsp_core #(
    .NEST_DEPTH  (NEST_DEPTH),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata),
    .max_bulk_i  (max_bulk_q),
    .max_array_i (max_array_q),
    .res_cnt_o   (res_cnt),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  rsp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (res_cnt),
    .push0_i     (res0),
    .push1_i     (res1),
    .space_o     (space),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (head)
  );

  // pack the head result
  assign m_axis_tdata = {1'b0, head.error_code, head.message_length, head.message_end,
                         head.token_null, head.token_end, head.payload_byte,
                         head.payload_valid};
  assign m_axis_tuser = head.token_type;
  assign m_axis_tlast = head.last_result;

endmodule
`default_nettype wire

[test/resp_parse_checker.sv]
// Result checker for the RESP stream parser: watches the byte, result and register channels.
// Predicts each byte's results from its own parser copy and compares them field by field.
// Depends on rsp_pkg.
`default_nettype none
module resp_parse_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [39:0] m_axis_tdata,
  input  wire logic [1:0]  m_axis_tuser,
  input  wire logic        m_axis_tlast,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i,
  output int               fail_cnt_o,
  output int               pending_o,
  output int               bytes_o,
  output int               messages_o,
  output int               errors_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rsp_pkg::*;

  localparam int unsigned DEPTH   = 8;
  localparam int unsigned HDR_CAP = 32'h0100_0000;
  localparam int unsigned LEN_SAT = 32'h00FF_FFFF;

  // Register copies
  logic [23:0] lim_bulk = MAX_BULK_RST;
  logic [15:0] lim_arr  = MAX_ARRAY_RST;

  // Parser copy
  mode_e       mode = M_IDLE;
  logic [2:0]  kind = '0;
  int unsigned hdr_val = 0;
  logic        hdr_neg = 1'b0;
  int unsigned bulk_left = 0;
  logic        cr_held = 1'b0;
  logic [15:0] arr_left [DEPTH];
  int unsigned level = 0;
  int unsigned msg_len = 0;

  result_t step_q [$];
  result_t result_q [$];

  initial begin
    fail_cnt_o = 0;
    pending_o  = 0;
    bytes_o    = 0;
    messages_o = 0;
    errors_o   = 0;
  end

  task automatic add_res(logic pv, logic [7:0] pb, logic [1:0] tt, logic te, logic tn,
                         logic me, logic [23:0] ml, logic [2:0] ec);
    result_t r;
    r.payload_valid  = pv;
    r.payload_byte   = pb;
    r.token_type     = tt;
    r.token_end      = te;
    r.token_null     = tn;
    r.message_end    = me;
    r.message_length = ml;
    r.error_code     = ec;
    r.last_result    = 1'b0;
    step_q.insert(step_q.size(), r);
    if (me) messages_o++;
    if (ec != ERR_NONE) errors_o++;
  endtask

  task automatic clear_parse();
    mode      = M_IDLE;
    kind      = '0;
    hdr_val   = 0;
    hdr_neg   = 1'b0;
    bulk_left = 0;
    cr_held   = 1'b0;
    level     = 0;
    msg_len   = 0;
  endtask

  task automatic flag_error(logic [2:0] code);
    add_res(1'b0, 8'h00, TT_SIMPLE, 1'b0, 1'b0, 1'b0, 24'd0, code);
    clear_parse();
  endtask

  // One element done: pop every exhausted array level; 1 when the message is whole
  function automatic logic pop_levels();
    while (level > 0) begin
      if (arr_left[level-1] > 1) begin
        arr_left[level-1]--;
        return 1'b0;
      end
      level--;
    end
    return 1'b1;
  endfunction

  task automatic close_element(logic te, logic [1:0] tt, logic tn);
    logic whole;
    whole   = pop_levels();
    mode    = M_IDLE;
    cr_held = 1'b0;
    if (whole) begin
      add_res(1'b0, 8'h00, te ? tt : TT_SIMPLE, te, tn, 1'b1, msg_len[23:0], ERR_NONE);
      msg_len = 0;
    end else if (te) begin
      add_res(1'b0, 8'h00, tt, 1'b1, tn, 1'b0, 24'd0, ERR_NONE);
    end
  endtask

  // Header closed by its LF
  task automatic header_done();
    logic neg;
    neg = hdr_neg && (hdr_val != 0);
    if (kind == KIND_BULK) begin
      if (neg) close_element(1'b1, TT_BULK, 1'b1);
      else if (hdr_val >= HDR_CAP || hdr_val > lim_bulk) flag_error(ERR_LIMIT);
      else begin
        bulk_left = hdr_val;
        mode = (hdr_val == 0) ? M_BCR : M_BDATA;
      end
    end else if (neg || hdr_val == 0) begin
      close_element(1'b0, TT_SIMPLE, 1'b0);
    end else if (hdr_val >= HDR_CAP || hdr_val > lim_arr) begin
      flag_error(ERR_LIMIT);
    end else if (level >= DEPTH) begin
      flag_error(ERR_DEPTH);
    end else begin
      arr_left[level] = hdr_val[15:0];
      level++;
      mode = M_IDLE;
    end
  endtask

  task automatic parse_byte(logic [7:0] b);
    int unsigned v;
    step_q.delete();
    if (mode == M_IDLE && level == 0) msg_len = 1;
    else if (msg_len < LEN_SAT) msg_len++;

    case (mode)
      M_IDLE: begin
        hdr_val = 0;
        hdr_neg = 1'b0;
        cr_held = 1'b0;
        case (b)
          CH_PLUS:   begin kind = KIND_SIMPLE; mode = M_LINE; end
          CH_MINUS:  begin kind = KIND_ERROR;  mode = M_LINE; end
          CH_COLON:  begin kind = KIND_INT;    mode = M_LINE; end
          CH_DOLLAR: begin kind = KIND_BULK;   mode = M_HSTART; end
          CH_STAR:   begin kind = KIND_ARRAY;  mode = M_HSTART; end
          default:   flag_error(ERR_PREFIX);
        endcase
      end
      M_LINE: begin
        if (cr_held && b == CH_LF) begin
          cr_held = 1'b0;
          close_element(1'b1, kind[1:0], 1'b0);
        end else begin
          // a lone CR goes out as content
          if (cr_held) begin
            cr_held = 1'b0;
            add_res(1'b1, CH_CR, kind[1:0], 1'b0, 1'b0, 1'b0, 24'd0, ERR_NONE);
          end
          if (b == CH_CR) cr_held = 1'b1;
          else add_res(1'b1, b, kind[1:0], 1'b0, 1'b0, 1'b0, 24'd0, ERR_NONE);
        end
      end
      M_HSTART, M_HSIGN, M_HDIG: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          v = hdr_val * 10 + (b - CH_ZERO);
          hdr_val = (v > HDR_CAP) ? HDR_CAP : v;
          mode = M_HDIG;
        end else if (b == CH_MINUS && mode == M_HSTART) begin
          hdr_neg = 1'b1;
          mode = M_HSIGN;
        end else if (b == CH_CR && mode == M_HDIG) begin
          mode = M_HLF;
        end else begin
          flag_error(ERR_HEADER);
        end
      end
      M_HLF: begin
        if (b == CH_LF) header_done();
        else flag_error(ERR_HEADER);
      end
      M_BDATA: begin
        add_res(1'b1, b, TT_BULK, 1'b0, 1'b0, 1'b0, 24'd0, ERR_NONE);
        if (bulk_left > 0) bulk_left--;
        if (bulk_left == 0) mode = M_BCR;
      end
      M_BCR: begin
        if (b == CH_CR) mode = M_BLF;
        else flag_error(ERR_HEADER);
      end
      M_BLF: begin
        if (b == CH_LF) close_element(1'b1, TT_BULK, 1'b0);
        else flag_error(ERR_HEADER);
      end
      default: clear_parse();
    endcase

    if (step_q.size() > 0) step_q[step_q.size()-1].last_result = 1'b1;
    foreach (step_q[i]) result_q.insert(result_q.size(), step_q[i]);
  endtask

  // Channel monitor
  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_MAX_BULK:  lim_bulk = cfg_data_i;
          REG_MAX_ARRAY: lim_arr  = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        bytes_o++;
        parse_byte(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.payload_valid  = m_axis_tdata[0];
        got.payload_byte   = m_axis_tdata[8:1];
        got.token_type     = m_axis_tuser;
        got.token_end      = m_axis_tdata[9];
        got.token_null     = m_axis_tdata[10];
        got.message_end    = m_axis_tdata[11];
        got.message_length = m_axis_tdata[35:12];
        got.error_code     = m_axis_tdata[38:36];
        got.last_result    = m_axis_tlast;
        if (result_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= 10)
            $display("%0t: result with none outstanding: %h", $realtime, got);
        end else begin
          want = result_q.pop_front();
          if (got !== want || m_axis_tdata[39] !== 1'b0) begin
            fail_cnt_o++;
            if (fail_cnt_o <= 10)
              $display("%0t: result mismatch: expected %h, got %h (pad %b)",
                       $realtime, want, got, m_axis_tdata[39]);
          end
        end
      end
      pending_o = result_q.size();
    end
  end

endmodule
`default_nettype wire

[test/tb_resp_stream_parser.sv]
// Testbench top for resp_stream_parser: clock, reset, byte stimulus and register writes.
// Depends on rsp_pkg, resp_stream_parser and resp_parse_checker.
`default_nettype none
module tb_resp_stream_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import rsp_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;

  int fail_cnt, pending, n_bytes, n_msgs, n_errs;
  int snd_gap_pct = 14;
  int rcv_gap_pct = 65;
  int quiet_cycles = 0;
  logic [7:0] stream_q [$];

  resp_stream_parser uut (.*);

  resp_parse_checker chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_cnt_o(fail_cnt), .pending_o(pending), .bytes_o(n_bytes),
    .messages_o(n_msgs), .errors_o(n_errs)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver back-pressure
  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= rcv_gap_pct);

  // Watchdog on channel inactivity
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Append one byte to the pending stream
  task automatic add_byte(logic [7:0] b);
    stream_q.insert(stream_q.size(), b);
  endtask

  // Entered and left at a falling edge; valid stays high for a following byte
  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < snd_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk_i);
  endtask

  task automatic flush_stream();
    foreach (stream_q[i]) send_byte(stream_q[i]);
    stream_q.delete();
  endtask

  // Sender holds off until every predicted result is back, plus latency margin
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic put_num(int n);
    put_str($sformatf("%0d", n));
  endtask

  function automatic logic [7:0] content_byte();
    logic [7:0] b;
    if ($urandom_range(9) == 0) return CH_CR;
    do b = $urandom_range(255); while (b == CH_CR || b == CH_LF);
    return b;
  endfunction

  // One well-formed element with random content
  task automatic add_element(int depth);
    int pick, n;
    pick = $urandom_range(99);
    if (pick < 36) begin
      case ($urandom_range(2))
        0: add_byte(CH_PLUS);
        1: add_byte(CH_MINUS);
        default: add_byte(CH_COLON);
      endcase
      n = $urandom_range(6);
      repeat (n) add_byte(content_byte());
      put_str("\r\n");
    end else if (pick < 72 || depth >= 10) begin
      add_byte(CH_DOLLAR);
      if ($urandom_range(11) == 0) begin
        put_str($urandom_range(1) ? "-1\r\n" : "-2\r\n");
      end else begin
        n = $urandom_range(8);
        if ($urandom_range(9) == 0) put_str("0");
        put_num(n);
        put_str("\r\n");
        repeat (n) add_byte($urandom_range(255));
        put_str("\r\n");
      end
    end else begin
      add_byte(CH_STAR);
      if ($urandom_range(15) == 0) begin
        put_str("-1\r\n");
      end else begin
        n = $urandom_range(3);
        put_num(n);
        put_str("\r\n");
        repeat (n) add_element(depth + 1);
      end
    end
  endtask

  // Mostly whole messages, some corrupted, some loose bytes
  task automatic random_phase(int n_items);
    int sent, pick, pos;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 7) begin
        add_byte($urandom_range(255));
      end else begin
        add_element(0);
        if (pick < 15) begin
          pos = $urandom_range(stream_q.size() - 1);
          stream_q[pos] = $urandom_range(255);
        end
      end
      sent += stream_q.size();
      flush_stream();
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: byte extremes, bare CR, null, negative zero, empty array, each error
    put_str("+\x00\xff\r\n-E\r\n:7\rX\r\n");
    put_str("$-1\r\n$-0\r\n\r\n*0\r\n");
    put_str("\r$x$1\r\nAB$99999999\r\n");
    repeat (9) put_str("*1\r\n");
    flush_stream();
    drain();

    // Zero limits
    write_reg(REG_MAX_BULK, 24'd0);
    write_reg(REG_MAX_ARRAY, 24'd0);
    put_str("$0\r\n\r\n$1\r\n*1\r\n*0\r\n");
    flush_stream();
    drain();

    write_reg(REG_MAX_BULK, 24'd5);
    write_reg(REG_MAX_ARRAY, 24'd2);
    random_phase(500);
    drain();

    // Largest limits; header saturation still trips the limit
    snd_gap_pct = 65;
    rcv_gap_pct = 14;
    write_reg(REG_MAX_BULK, 24'hFF_FFFF);
    write_reg(REG_MAX_ARRAY, 24'h00_FFFF);
    put_str("$16777216\r\n*65536\r\n");
    flush_stream();
    random_phase(500);
    drain();

    snd_gap_pct = 0;
    rcv_gap_pct = 0;
    write_reg(REG_MAX_BULK, MAX_BULK_RST);
    write_reg(REG_MAX_ARRAY, 24'(MAX_ARRAY_RST));
    random_phase(500);
    drain();

    $display("Covered %0d stream bytes, %0d complete messages, %0d parse errors",
             n_bytes, n_msgs, n_errs);
    $display("across four limit settings and three back-pressure profiles");
    if (fail_cnt == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_cnt, pending);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
